// File: rtl/core/zafe_pkg.sv
// Shared types and constants for the API-mode radio frame encoder.
package zafe_pkg;

    // One input word: a frame start with header fields, or one payload byte.
    typedef struct packed {
        logic        start_of_frame;
        logic [7:0]  frame_type;
        logic [7:0]  msg_id;
        logic [63:0] dest_addr64;
        logic [15:0] dest_addr16;
        logic [7:0]  payload_length;
        logic [7:0]  data_byte;
    } in_word_t;

    // One output word: one encoded byte on the serial line.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       frame_end;
        logic [1:0] status;
    } out_word_t;

    // Status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_TYPE = 2'd1;
    localparam logic [1:0] ST_NO_FRAME = 2'd2;

    // Frame types and fixed bytes.
    localparam logic [7:0] FT_AT_CMD     = 8'h08;
    localparam logic [7:0] FT_TX_REQ     = 8'h10;
    localparam logic [7:0] FT_REMOTE_AT  = 8'h17;
    localparam logic [7:0] START_DELIM   = 8'h7E;
    localparam logic [7:0] REMOTE_AT_OPT = 8'h02;
    localparam logic [7:0] ZERO_BYTE     = 8'h00;

    // Bytes of type plus header counted in the length field.
    localparam logic [8:0] HDR_LEN_AT  = 9'd2;
    localparam logic [8:0] HDR_LEN_TX  = 9'd14;
    localparam logic [8:0] HDR_LEN_RAT = 9'd13;

    // Header burst lengths in output bytes: delimiter, length, type and header.
    localparam logic [4:0] HDR_STEPS_AT  = 5'd5;
    localparam logic [4:0] HDR_STEPS_TX  = 5'd17;
    localparam logic [4:0] HDR_STEPS_RAT = 5'd16;
    localparam logic [4:0] HDR_STEPS_NONE = 5'd0;

    // Kinds of work handed from the front to the back.
    typedef enum logic [1:0] {
        CMD_FRAME,
        CMD_DATA,
        CMD_ERR_TYPE,
        CMD_ERR_DATA
    } cmd_kind_t;

    // One command for the back end: everything needed to emit an item's bytes.
    typedef struct packed {
        cmd_kind_t   kind;
        logic [7:0]  frame_type;
        logic [7:0]  msg_id;
        logic [63:0] dest_addr64;
        logic [15:0] dest_addr16;
        logic [8:0]  frame_len;
        logic [4:0]  hdr_steps;
        logic [7:0]  data_byte;
        logic        has_data;
        logic        close;
    } cmd_t;

    // Depth of the command queue between front and back.
    localparam int CMD_QUEUE_DEPTH = 2;

endpackage

// File: rtl/core/zafe_front.sv
// Front end: accepts input words, tracks frame state and classifies each word.
module zafe_front #(
    parameter int MAX_PAYLOAD = 255
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  zafe_pkg::in_word_t item,
    output zafe_pkg::cmd_t    cmd
);

    logic       in_frame_reg;
    logic       in_frame_next;
    logic [7:0] bytes_left_reg;
    logic [7:0] bytes_left_next;
    logic [7:0] plen_sat;
    logic [7:0] left_dec;

    // Classify the word and work out the frame state it leaves behind.
    always_comb
    begin
        plen_sat = (item.payload_length > 8'(MAX_PAYLOAD)) ? 8'(MAX_PAYLOAD)
                                                           : item.payload_length;
        left_dec = (bytes_left_reg != 8'd0) ? bytes_left_reg - 8'd1 : 8'd0;

        cmd.kind        = zafe_pkg::CMD_ERR_DATA;
        cmd.frame_type  = item.frame_type;
        cmd.msg_id      = item.msg_id;
        cmd.dest_addr64 = item.dest_addr64;
        cmd.dest_addr16 = item.dest_addr16;
        cmd.frame_len   = 9'd0;
        cmd.hdr_steps   = zafe_pkg::HDR_STEPS_NONE;
        cmd.data_byte   = item.data_byte;
        cmd.has_data    = 1'b0;
        cmd.close       = 1'b0;

        in_frame_next   = in_frame_reg;
        bytes_left_next = bytes_left_reg;

        if (item.start_of_frame)
        begin
            cmd.kind     = zafe_pkg::CMD_FRAME;
            cmd.has_data = (plen_sat != 8'd0);
            cmd.close    = (plen_sat <= 8'd1);
            unique case (item.frame_type)
                zafe_pkg::FT_AT_CMD:
                begin
                    cmd.hdr_steps = zafe_pkg::HDR_STEPS_AT;
                    cmd.frame_len = zafe_pkg::HDR_LEN_AT + 9'(plen_sat);
                end
                zafe_pkg::FT_TX_REQ:
                begin
                    cmd.hdr_steps = zafe_pkg::HDR_STEPS_TX;
                    cmd.frame_len = zafe_pkg::HDR_LEN_TX + 9'(plen_sat);
                end
                zafe_pkg::FT_REMOTE_AT:
                begin
                    cmd.hdr_steps = zafe_pkg::HDR_STEPS_RAT;
                    cmd.frame_len = zafe_pkg::HDR_LEN_RAT + 9'(plen_sat);
                end
                default:
                begin
                    cmd.kind     = zafe_pkg::CMD_ERR_TYPE;
                    cmd.has_data = 1'b0;
                    cmd.close    = 1'b0;
                end
            endcase

            if (cmd.kind == zafe_pkg::CMD_ERR_TYPE)
            begin
                in_frame_next   = 1'b0;
                bytes_left_next = 8'd0;
            end
            else
            begin
                in_frame_next   = (plen_sat > 8'd1);
                bytes_left_next = (plen_sat > 8'd1) ? plen_sat - 8'd1 : 8'd0;
            end
        end
        else if (in_frame_reg)
        begin
            // Payload byte inside an open frame; the last one closes it.
            cmd.kind     = zafe_pkg::CMD_DATA;
            cmd.has_data = 1'b1;
            cmd.close    = (left_dec == 8'd0);
            in_frame_next   = (left_dec != 8'd0);
            bytes_left_next = left_dec;
        end
    end

    // Frame state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg   <= 1'b0;
            bytes_left_reg <= 8'd0;
        end
        else if (take)
        begin
            in_frame_reg   <= in_frame_next;
            bytes_left_reg <= bytes_left_next;
        end
    end

endmodule

// File: rtl/core/zafe_queue.sv
// Short command queue between the front end and the back end.
module zafe_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  zafe_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output zafe_pkg::cmd_t head
);

    localparam int PtrW = $clog2(zafe_pkg::CMD_QUEUE_DEPTH);

    zafe_pkg::cmd_t     entry_reg [zafe_pkg::CMD_QUEUE_DEPTH];
    logic [PtrW-1:0]    wr_ptr_reg;
    logic [PtrW-1:0]    rd_ptr_reg;
    logic [PtrW:0]      count_reg;

    assign full      = (count_reg == (PtrW+1)'(zafe_pkg::CMD_QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];

    // Entry storage holds payload only.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: rtl/core/zafe_back.sv
// Back end: steps through each command and emits one encoded byte per cycle unless the result side stalls.
module zafe_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    input  zafe_pkg::cmd_t      cmd,
    output logic                cmd_pop,
    output logic                result_valid,
    input  logic                result_stall,
    output zafe_pkg::out_word_t result
);

    localparam logic [4:0] STEP_DELIM   = 5'd0;
    localparam logic [4:0] STEP_LEN_HI  = 5'd1;
    localparam logic [4:0] STEP_LEN_LO  = 5'd2;
    localparam logic [4:0] STEP_TYPE    = 5'd3;
    localparam logic [4:0] STEP_ID      = 5'd4;
    localparam logic [4:0] STEP_ADDR64  = 5'd5;
    localparam logic [4:0] STEP_A16_HI  = 5'd13;
    localparam logic [4:0] STEP_A16_LO  = 5'd14;
    localparam logic [4:0] STEP_OPT_A   = 5'd15;
    localparam logic [4:0] STEP_OPT_B   = 5'd16;

    logic [4:0]          step_reg;
    logic [4:0]          step_next;
    logic [7:0]          sum_reg;
    logic [7:0]          sum_next;
    logic                result_valid_reg;
    logic                result_valid_next;
    zafe_pkg::out_word_t result_reg;
    zafe_pkg::out_word_t result_next;

    logic       advance;
    logic       fire;
    logic       is_err;
    logic       is_hdr;
    logic       is_data;
    logic       is_check;
    logic       last;
    logic       summed;
    logic [4:0] last_step;
    logic [2:0] addr_sel;
    logic [7:0] hdr_byte;
    logic [7:0] emit_byte;

    assign advance = !result_valid_reg || !result_stall;
    assign fire    = advance && cmd_valid;
    assign cmd_pop = fire && last;

    // Header byte at the current step.
    always_comb
    begin
        addr_sel = 3'd7 - 3'(step_reg - STEP_ADDR64);
        hdr_byte = zafe_pkg::ZERO_BYTE;
        unique case (step_reg) inside
            STEP_DELIM:  hdr_byte = zafe_pkg::START_DELIM;
            STEP_LEN_HI: hdr_byte = {7'd0, cmd.frame_len[8]};
            STEP_LEN_LO: hdr_byte = cmd.frame_len[7:0];
            STEP_TYPE:   hdr_byte = cmd.frame_type;
            STEP_ID:     hdr_byte = cmd.msg_id;
            [STEP_ADDR64:STEP_ADDR64+5'd7]:
                hdr_byte = cmd.dest_addr64[{addr_sel, 3'b000} +: 8];
            STEP_A16_HI: hdr_byte = cmd.dest_addr16[15:8];
            STEP_A16_LO: hdr_byte = cmd.dest_addr16[7:0];
            STEP_OPT_A:
                hdr_byte = (cmd.frame_type == zafe_pkg::FT_REMOTE_AT)
                           ? zafe_pkg::REMOTE_AT_OPT : zafe_pkg::ZERO_BYTE;
            STEP_OPT_B:  hdr_byte = zafe_pkg::ZERO_BYTE;
            default:     hdr_byte = zafe_pkg::ZERO_BYTE;
        endcase
    end

    // Decide what this step emits and whether it ends the command.
    always_comb
    begin
        is_err    = (cmd.kind == zafe_pkg::CMD_ERR_TYPE) ||
                    (cmd.kind == zafe_pkg::CMD_ERR_DATA);
        is_hdr    = !is_err && (step_reg < cmd.hdr_steps);
        is_data   = !is_err && !is_hdr && cmd.has_data && (step_reg == cmd.hdr_steps);
        is_check  = !is_err && !is_hdr && !is_data;
        last_step = cmd.hdr_steps + 5'(cmd.has_data) + 5'(cmd.close) - 5'd1;
        last      = is_err || (step_reg == last_step);
        summed    = is_data || (is_hdr && (step_reg >= STEP_TYPE));

        if (is_hdr)
        begin
            emit_byte = hdr_byte;
        end
        else if (is_data)
        begin
            emit_byte = cmd.data_byte;
        end
        else if (is_check)
        begin
            emit_byte = ~sum_reg;
        end
        else
        begin
            emit_byte = zafe_pkg::ZERO_BYTE;
        end
    end

    // Next values for the step counter, checksum and output register.
    always_comb
    begin
        step_next         = step_reg;
        sum_next          = sum_reg;
        result_valid_next = result_valid_reg;
        result_next       = result_reg;

        if (advance)
        begin
            result_valid_next = cmd_valid;
        end

        if (fire)
        begin
            step_next = last ? 5'd0 : step_reg + 5'd1;

            if (cmd.kind == zafe_pkg::CMD_FRAME && step_reg == STEP_DELIM)
            begin
                sum_next = 8'd0;
            end
            else if (summed)
            begin
                sum_next = sum_reg + emit_byte;
            end

            result_next.out_byte  = emit_byte;
            result_next.run_last  = last;
            result_next.frame_end = is_check;
            if (cmd.kind == zafe_pkg::CMD_ERR_TYPE)
            begin
                result_next.status = zafe_pkg::ST_BAD_TYPE;
            end
            else if (cmd.kind == zafe_pkg::CMD_ERR_DATA)
            begin
                result_next.status = zafe_pkg::ST_NO_FRAME;
            end
            else
            begin
                result_next.status = zafe_pkg::ST_OK;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg         <= 5'd0;
            sum_reg          <= 8'd0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg         <= step_next;
            sum_reg          <= sum_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Output word register.
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// File: rtl/core/zigbee_api_frame_encoder.sv
// Top level of the API-mode radio frame encoder.
//
//   channel  | direction | handshake                   | word
//   item     | in        | item_valid / item_stall     | zafe_pkg::in_word_t
//   result   | out       | result_valid / result_stall | zafe_pkg::out_word_t
//
// Unless stalled, the back end emits one byte per cycle: a payload word gives one
// byte, or two when it closes the frame; a known-type start word gives 5, 16 or
// 17 header bytes, any first payload byte and, for a short payload, the checksum.
// The front takes a word each cycle while the two-entry command queue has room.
// Reset empties the queue and clears the frame state; no clearing pass is needed.
// A stall on the result side holds the output register and backs up into the
// queue, which then stalls the item side.
module zigbee_api_frame_encoder #(
    parameter int MAX_PAYLOAD = 255
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  zafe_pkg::in_word_t  item,
    output logic                result_valid,
    input  logic                result_stall,
    output zafe_pkg::out_word_t result
);

    zafe_pkg::cmd_t new_cmd;
    zafe_pkg::cmd_t head_cmd;
    logic           take;
    logic           queue_full;
    logic           queue_not_empty;
    logic           queue_pop;

    assign item_stall = queue_full;
    assign take       = item_valid && !queue_full;

    // Front end: classify accepted words.
    zafe_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .item  (item),
        .cmd   (new_cmd)
    );

    // Command queue.
    zafe_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (take),
        .push_cmd  (new_cmd),
        .full      (queue_full),
        .pop       (queue_pop),
        .not_empty (queue_not_empty),
        .head      (head_cmd)
    );

    // Back end: byte sequencer and output register.
    zafe_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (queue_not_empty),
        .cmd          (head_cmd),
        .cmd_pop      (queue_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// File: rtl/core/zafe_checker.sv
// Port-level checks for the frame encoder and their bind to the top level.
module zafe_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                item_stall,
    input logic                result_valid,
    input logic                result_stall,
    input zafe_pkg::out_word_t result
);

    // A stalled output word holds.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result word changed");

    // The checksum is always the last byte of its input word.
    a_check_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.frame_end |-> result.run_last)
        else $error("checksum not marked as last byte");

    // An error word stands alone, carries a zero byte and no frame end.
    a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.status != zafe_pkg::ST_OK) |->
            result.run_last && !result.frame_end &&
            (result.out_byte == zafe_pkg::ZERO_BYTE))
        else $error("malformed error word");

    // Only the defined status codes appear.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.status == zafe_pkg::ST_OK) ||
            (result.status == zafe_pkg::ST_BAD_TYPE) ||
            (result.status == zafe_pkg::ST_NO_FRAME))
        else $error("undefined status code");

    // The input side only stalls while a result word is waiting.
    a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> result_valid)
        else $error("input stalled with no result pending");

endmodule

bind zigbee_api_frame_encoder zafe_checker u_zafe_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

// File: dv/tb_zigbee_api_frame_encoder.sv
// Self-checking testbench for the API-mode radio frame encoder.
module tb_zigbee_api_frame_encoder;
    timeunit 1ns;
    timeprecision 1ps;

    // Checksum base and the frame types the block does not finish.
    localparam logic [7:0] CHECK_BASE      = 8'hFF;
    localparam logic [7:0] FT_EXPLICIT_TX  = 8'h11;
    localparam logic [7:0] FT_SOURCE_ROUTE = 8'h21;
    localparam logic [7:0] FT_MODEM_STATUS = 8'h8A;

    // Run length and waiting limits.
    localparam int RANDOM_ITEMS   = 360;
    localparam int CYCLE_LIMIT    = 1500000;
    localparam int DRAIN_CYCLES   = 60;
    localparam int PRESSURE_AFTER = 150;
    localparam int PRESSURE_HOLD  = 300;

    // Frame encoder prediction and the queue of bytes still to come.
    class frame_scoreboard;
        zafe_pkg::out_word_t expected_bytes[$];
        int                  mismatches;
        int                  bytes_checked;
        bit                  frame_open;
        logic [7:0]          payload_left;
        logic [7:0]          byte_sum;

        function new();
            mismatches = 0;
            bytes_checked = 0;
            frame_open = 1'b0;
            payload_left = '0;
            byte_sum = '0;
        endfunction

        task report_mismatch(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            mismatches++;
        endtask

        function void push_byte(logic [7:0] b, logic is_check, logic [1:0] code);
            zafe_pkg::out_word_t r;
            r.out_byte = b;
            r.run_last = 1'b0;
            r.frame_end = is_check;
            r.status = code;
            expected_bytes.push_back(r);
        endfunction

        // Bytes from the type through the payload count toward the checksum.
        function void push_summed(logic [7:0] b);
            byte_sum = byte_sum + b;
            push_byte(b, 1'b0, zafe_pkg::ST_OK);
        endfunction

        function void push_checksum();
            push_byte(CHECK_BASE - byte_sum, 1'b1, zafe_pkg::ST_OK);
            frame_open = 1'b0;
            payload_left = '0;
        endfunction

        // Work out every byte that one accepted item word causes.
        function void encode_item(zafe_pkg::in_word_t w);
            logic [8:0]          hdr_len;
            logic [15:0]         frame_len;
            zafe_pkg::out_word_t tail;
            if (w.start_of_frame)
            begin
                case (w.frame_type)
                    zafe_pkg::FT_AT_CMD:    hdr_len = zafe_pkg::HDR_LEN_AT;
                    zafe_pkg::FT_TX_REQ:    hdr_len = zafe_pkg::HDR_LEN_TX;
                    zafe_pkg::FT_REMOTE_AT: hdr_len = zafe_pkg::HDR_LEN_RAT;
                    default:                hdr_len = '0;
                endcase
                if (hdr_len == '0)
                begin
                    // Unsupported type drops any open frame.
                    frame_open = 1'b0;
                    payload_left = '0;
                    byte_sum = '0;
                    push_byte(zafe_pkg::ZERO_BYTE, 1'b0, zafe_pkg::ST_BAD_TYPE);
                end
                else
                begin
                    // An 8-bit length never exceeds the payload limit of 255.
                    frame_len = 16'(hdr_len) + 16'(w.payload_length);
                    push_byte(zafe_pkg::START_DELIM, 1'b0, zafe_pkg::ST_OK);
                    push_byte(frame_len[15:8], 1'b0, zafe_pkg::ST_OK);
                    push_byte(frame_len[7:0], 1'b0, zafe_pkg::ST_OK);
                    byte_sum = '0;
                    push_summed(w.frame_type);
                    push_summed(w.msg_id);
                    if (w.frame_type != zafe_pkg::FT_AT_CMD)
                    begin
                        for (int i = 7; i >= 0; i--)
                            push_summed(w.dest_addr64[i*8 +: 8]);
                        push_summed(w.dest_addr16[15:8]);
                        push_summed(w.dest_addr16[7:0]);
                        if (w.frame_type == zafe_pkg::FT_TX_REQ)
                        begin
                            push_summed(zafe_pkg::ZERO_BYTE);
                            push_summed(zafe_pkg::ZERO_BYTE);
                        end
                        else
                            push_summed(zafe_pkg::REMOTE_AT_OPT);
                    end
                    if (w.payload_length == '0)
                        push_checksum();
                    else
                    begin
                        push_summed(w.data_byte);
                        payload_left = w.payload_length - 8'd1;
                        if (payload_left == '0)
                            push_checksum();
                        else
                            frame_open = 1'b1;
                    end
                end
            end
            else if (!frame_open)
                push_byte(zafe_pkg::ZERO_BYTE, 1'b0, zafe_pkg::ST_NO_FRAME);
            else
            begin
                push_summed(w.data_byte);
                if (payload_left != '0)
                    payload_left = payload_left - 8'd1;
                if (payload_left == '0)
                    push_checksum();
            end
            // The last byte of the burst closes the run.
            tail = expected_bytes.pop_back();
            tail.run_last = 1'b1;
            expected_bytes.push_back(tail);
        endfunction

        // Compare one accepted result word with the oldest expectation.
        task check_byte(zafe_pkg::out_word_t got);
            zafe_pkg::out_word_t want;
            bytes_checked++;
            if (expected_bytes.size() == 0)
            begin
                report_mismatch($sformatf("unexpected byte %02h with nothing pending",
                                          got.out_byte));
                return;
            end
            want = expected_bytes.pop_front();
            if (got.out_byte !== want.out_byte)
                report_mismatch($sformatf("out_byte %02h, wanted %02h",
                                          got.out_byte, want.out_byte));
            if (got.run_last !== want.run_last)
                report_mismatch($sformatf("run_last %b, wanted %b",
                                          got.run_last, want.run_last));
            if (got.frame_end !== want.frame_end)
                report_mismatch($sformatf("frame_end %b, wanted %b",
                                          got.frame_end, want.frame_end));
            if (got.status !== want.status)
                report_mismatch($sformatf("status %0d, wanted %0d",
                                          got.status, want.status));
        endtask

        task check_leftovers();
            if (expected_bytes.size() != 0)
                report_mismatch($sformatf("%0d expected bytes never arrived",
                                          expected_bytes.size()));
        endtask
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                item_valid = 1'b0;
    logic                item_stall;
    zafe_pkg::in_word_t  item = '0;
    logic                result_valid;
    logic                result_stall = 1'b0;
    zafe_pkg::out_word_t result;

    frame_scoreboard    sb = new();
    zafe_pkg::in_word_t plan[$];
    int                 cycle_count = 0;

    zigbee_api_frame_encoder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // Clock and reset.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Run guard.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[zigbee_api_frame_encoder] ERROR");
            $finish;
        end
    end

    // Mostly short idle gaps, now and then a long one.
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic zafe_pkg::in_word_t rand_word();
        zafe_pkg::in_word_t w;
        w.start_of_frame = 1'($urandom_range(0, 1));
        w.frame_type = 8'($urandom_range(0, 255));
        w.msg_id = 8'($urandom_range(0, 255));
        w.dest_addr64 = {$urandom, $urandom};
        w.dest_addr16 = 16'($urandom_range(0, 65535));
        w.payload_length = 8'($urandom_range(0, 255));
        w.data_byte = 8'($urandom_range(0, 255));
        return w;
    endfunction

    // A payload word; the header fields carry junk that the block must ignore.
    function automatic zafe_pkg::in_word_t data_word(logic [7:0] db);
        zafe_pkg::in_word_t w;
        w = rand_word();
        w.start_of_frame = 1'b0;
        w.data_byte = db;
        return w;
    endfunction

    function automatic zafe_pkg::in_word_t start_word(logic [7:0] ft, logic [7:0] id,
                                                      logic [63:0] a64, logic [15:0] a16,
                                                      logic [7:0] plen, logic [7:0] db);
        zafe_pkg::in_word_t w;
        w.start_of_frame = 1'b1;
        w.frame_type = ft;
        w.msg_id = id;
        w.dest_addr64 = a64;
        w.dest_addr16 = a16;
        w.payload_length = plen;
        w.data_byte = db;
        return w;
    endfunction

    function automatic logic [7:0] good_type();
        case ($urandom_range(0, 2))
            0:       return zafe_pkg::FT_AT_CMD;
            1:       return zafe_pkg::FT_TX_REQ;
            default: return zafe_pkg::FT_REMOTE_AT;
        endcase
    endfunction

    function automatic logic [7:0] odd_type();
        logic [7:0] t;
        case ($urandom_range(0, 5))
            0: return FT_EXPLICIT_TX;
            1: return FT_SOURCE_ROUTE;
            2: return FT_MODEM_STATUS;
            default:
            begin
                t = 8'($urandom_range(0, 255));
                while (t == zafe_pkg::FT_AT_CMD || t == zafe_pkg::FT_TX_REQ ||
                       t == zafe_pkg::FT_REMOTE_AT)
                    t = 8'($urandom_range(0, 255));
                return t;
            end
        endcase
    endfunction

    // Payload sizes: mostly short, rarely near the limit.
    function automatic int pick_payload();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 0;
        if (r < 80)
            return $urandom_range(1, 8);
        if (r < 96)
            return $urandom_range(9, 40);
        return $urandom_range(200, 255);
    endfunction

    // Directed words: field extremes, every type and each corner case.
    task automatic plan_directed();
        // Payload word before any frame is open.
        plan.push_back(data_word(8'hFF));
        // Zero payload: checksum rides in the header burst, data ignored.
        plan.push_back(start_word(zafe_pkg::FT_AT_CMD, 8'h00, '0, '0, 8'd0, 8'hFF));
        plan.push_back(start_word(zafe_pkg::FT_AT_CMD, 8'hFF, '1, '1, 8'd1, 8'hFF));
        plan.push_back(start_word(zafe_pkg::FT_TX_REQ, 8'hA5, '1, '1, 8'd3, 8'h00));
        plan.push_back(data_word(8'hFF));
        plan.push_back(data_word(8'h5A));
        plan.push_back(start_word(zafe_pkg::FT_REMOTE_AT, 8'h3C, '0, '0, 8'd0, 8'h00));
        plan.push_back(start_word(zafe_pkg::FT_REMOTE_AT, 8'h01, 64'h0123_4567_89AB_CDEF,
                                  16'hFFFE, 8'd4, 8'h80));
        plan.push_back(data_word(8'h01));
        // New start abandons the open frame; longest payload sets the length high byte.
        plan.push_back(start_word(zafe_pkg::FT_TX_REQ, 8'h80, 64'hFEDC_BA98_7654_3210,
                                  16'h0001, 8'd255, 8'h7F));
        plan.push_back(data_word(8'hC3));
        // Unfinished types drop the open frame and report an error.
        plan.push_back(start_word(FT_EXPLICIT_TX, 8'h11, '1, '1, 8'd5, 8'h11));
        plan.push_back(data_word(8'h00));
        plan.push_back(start_word(FT_SOURCE_ROUTE, 8'h22, '0, '0, 8'd0, 8'h00));
        plan.push_back(start_word(FT_MODEM_STATUS, 8'h33, '1, '0, 8'd255, 8'hFF));
        plan.push_back(start_word(8'hFF, 8'hFF, '1, '1, 8'd255, 8'hFF));
        plan.push_back(start_word(8'h00, 8'h00, '0, '0, 8'd0, 8'h00));
        plan.push_back(start_word(zafe_pkg::FT_REMOTE_AT, 8'hFF, '1, '1, 8'd255, 8'hFF));
        plan.push_back(start_word(zafe_pkg::FT_AT_CMD, 8'h55, '0, '0, 8'd2, 8'hAA));
        plan.push_back(data_word(8'h55));
        plan.push_back(start_word(zafe_pkg::FT_TX_REQ, 8'h00, '0, '0, 8'd0, 8'h00));
    endtask

    // Random words: mostly complete frames, some cut short, some noise.
    task automatic plan_random();
        int                 made;
        int                 kind;
        int                 plen;
        int                 cut;
        zafe_pkg::in_word_t w;
        made = 0;
        while (made < RANDOM_ITEMS)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 6)
            begin
                w = rand_word();
                w.start_of_frame = 1'b1;
                w.frame_type = odd_type();
                plan.push_back(w);
                made++;
            end
            else if (kind < 11)
            begin
                plan.push_back(data_word(8'($urandom_range(0, 255))));
                made++;
            end
            else
            begin
                plen = pick_payload();
                w = rand_word();
                w.start_of_frame = 1'b1;
                w.frame_type = good_type();
                w.payload_length = 8'(plen);
                plan.push_back(w);
                made++;
                cut = plen;
                if (plen > 1 && $urandom_range(0, 9) == 0)
                    cut = $urandom_range(1, plen - 1);
                if (plen >= 200 && $urandom_range(0, 3) != 0)
                    cut = $urandom_range(1, 12);
                for (int k = 1; k < cut; k++)
                begin
                    plan.push_back(data_word(8'($urandom_range(0, 255))));
                    made++;
                end
                // A broken frame ends on a bad type or on the next start.
                if (cut < plen && $urandom_range(0, 1) == 1)
                begin
                    w = rand_word();
                    w.start_of_frame = 1'b1;
                    w.frame_type = odd_type();
                    plan.push_back(w);
                    made++;
                end
            end
        end
    endtask

    // Offer the planned words with random gaps and some back-to-back stretches.
    task automatic send_plan();
        zafe_pkg::in_word_t w;
        int                 gap;
        int                 quiet_left;
        quiet_left = 0;
        while (plan.size() != 0)
        begin
            w = plan.pop_front();
            if (quiet_left > 0)
            begin
                quiet_left--;
                gap = 0;
            end
            else
            begin
                gap = pick_idle();
                if ($urandom_range(0, 15) == 0)
                    quiet_left = $urandom_range(20, 60);
            end
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            item <= w;
            item_valid <= 1'b1;
            @(posedge clk);
            while (item_stall)
                @(posedge clk);
        end
        item_valid <= 1'b0;
    endtask

    // Result side stalls: random bursts, free stretches and one long hold.
    initial
    begin : result_side
        int  hold_left;
        int  stall_left;
        int  free_left;
        bit  held;
        hold_left = 0;
        stall_left = 0;
        free_left = 0;
        held = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!held && sb.bytes_checked >= PRESSURE_AFTER)
            begin
                held = 1'b1;
                hold_left = PRESSURE_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                result_stall <= 1'b1;
            end
            else if (free_left > 0)
            begin
                free_left--;
                result_stall <= 1'b0;
            end
            else
            begin
                if ($urandom_range(0, 9) == 0)
                    free_left = $urandom_range(50, 150);
                else
                    free_left = $urandom_range(0, 6);
                stall_left = pick_idle();
                result_stall <= 1'b0;
            end
        end
    end

    // Watch both channels; a word noted at an edge precedes its results.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && !item_stall)
                sb.encode_item(item);
            if (result_valid && !result_stall)
                sb.check_byte(result);
        end
    end

    // Stimulus and end of run.
    initial
    begin
        plan_directed();
        plan_random();
        wait (rst_n === 1'b1);
        @(posedge clk);
        send_plan();
        @(posedge clk);
        while (sb.expected_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        sb.check_leftovers();
        if (sb.mismatches == 0)
            $display("[zigbee_api_frame_encoder] OK");
        else
            $display("[zigbee_api_frame_encoder] ERROR");
        $finish;
    end

endmodule
